// ===== hdl/cfr_pkg.sv =====
// Package for the four-window crossfade router: widths, register indexes, window centres.
package cfr_pkg;

  localparam int SAMPLE_W    = 10;
  localparam int LEVEL_W     = 12;
  localparam int GAIN_W      = 13;
  localparam int SUM_W       = 15;
  localparam int POS_W       = 12;  // signed window position, -512..1534
  localparam int WIDTH_W     = 11;  // signed window width, -127..1023
  localparam int SCAN_W      = 4;
  localparam int ROUTE_W     = 2;
  localparam int N_CHAN      = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_BASE    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LED_THRESHOLD = 1'd1;

  localparam logic [SAMPLE_W-1:0] WIDTH_BASE_RESET    = 10'd339;
  localparam logic [LEVEL_W-1:0]  LED_THRESHOLD_RESET = 12'd1024;
  localparam logic [POS_W-1:0]    POS_CENTRE          = 12'd512;
  localparam logic [SUM_W-1:0]    LEVEL_MAX           = 15'd4095;
  localparam logic [ROUTE_W-1:0]  CHAN_XOR            = 2'd2;

  typedef logic [ROUTE_W-1:0] route_t;
  typedef route_t [N_CHAN-1:0] route_map_t;
  typedef logic [GAIN_W-1:0] gain_t;

  typedef logic signed [POS_W-1:0] centre_arr_t [N_CHAN];
  localparam centre_arr_t CENTRES = '{12'sd0, 12'sd341, 12'sd682, 12'sd1023};

endpackage

// ===== hdl/cfr_if.sv =====
// Valid/ready channel interfaces for scan items and level results.
interface cfr_scan_if
  import cfr_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic                switch_closed;
  logic [SAMPLE_W-1:0] cv_sample;
  logic [SAMPLE_W-1:0] position_sample;
  logic [SAMPLE_W-1:0] width_sample;

  modport source (output valid, switch_closed, cv_sample, position_sample, width_sample,
                  input ready);
  modport sink   (input valid, switch_closed, cv_sample, position_sample, width_sample,
                  output ready);
endinterface

interface cfr_level_if
  import cfr_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level_a;
  logic [LEVEL_W-1:0] level_b;
  logic [LEVEL_W-1:0] level_c;
  logic [LEVEL_W-1:0] level_d;
  logic [N_CHAN-1:0]  led_mask;
  logic [SCAN_W-1:0]  next_scan_position;

  modport source (output valid, level_a, level_b, level_c, level_d, led_mask,
                  next_scan_position, input ready);
  modport sink   (input valid, level_a, level_b, level_c, level_d, led_mask,
                  next_scan_position, output ready);
endinterface

// ===== hdl/cfr_window.sv =====
// Triangular window gain for one channel: max(0, w - |x - centre|) << 3.
module cfr_window
  import cfr_pkg::*;
(
  input  logic signed [POS_W-1:0]   pos,
  input  logic signed [WIDTH_W-1:0] width,
  input  logic signed [POS_W-1:0]   centre,
  output gain_t                     gain
);

  logic signed [POS_W:0]   delta_s;
  logic        [POS_W-1:0] delta;
  logic signed [POS_W+1:0] diff;

  always_comb begin
    delta_s = {pos[POS_W-1], pos} - {centre[POS_W-1], centre};  // one bit wider, no overflow
    delta   = delta_s[POS_W] ? POS_W'(-delta_s) : delta_s[POS_W-1:0];
    diff    = (POS_W+2)'(width) - $signed({2'b00, delta});
    if (diff[POS_W+1]) begin
      gain = '0;
    end else begin
      gain = {diff[SAMPLE_W-1:0], 3'b000};
    end
  end

endmodule

// ===== hdl/four_window_crossfade_router.sv =====
// Top level of the four-window crossfade router: scan routing, window gains, output sums.
//
//   channel  dir  fields
//   -------  ---  ------------------------------------------------------------
//   scan     in   switch_closed, cv_sample, position_sample, width_sample
//   levels   out  level_a..level_d, led_mask, next_scan_position
//   cfg      in   cfg_write, cfg_index, cfg_data (width_base, led_threshold)
//
// One beat per cycle sustained while levels is not stalled; each scan beat
// passes the input register, then gain/sum logic and the result register.
// rst is synchronous: scan position to 0, routes to identity, registers to
// their reset values, both stages empty.
// A stall on levels holds the result register; the input register still takes
// one more beat if empty, then scan.ready drops until the result is taken.
module four_window_crossfade_router
  import cfr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  cfr_scan_if.sink               scan,
  cfr_level_if.source            levels
);

  // configuration
  logic [SAMPLE_W-1:0] width_base;
  logic [LEVEL_W-1:0]  led_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_base    <= WIDTH_BASE_RESET;
      led_threshold <= LED_THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDTH_BASE:    width_base    <= cfg_data[SAMPLE_W-1:0];
        REG_LED_THRESHOLD: led_threshold <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // scan state: updated at the accepting edge, so each item sees the
  // routes as they stand after its own switch sample
  logic [SCAN_W-1:0] scan_position;
  route_map_t        route;
  route_map_t        route_next;
  logic [SCAN_W-1:0] scan_position_next;
  route_t            sel_chan;

  logic scan_accept;
  logic s1_valid;
  logic s1_advance;
  logic out_valid;

  assign s1_advance  = !out_valid || levels.ready;
  assign scan.ready  = !s1_valid || s1_advance;
  assign scan_accept = scan.valid && scan.ready;

  always_comb begin
    sel_chan           = scan_position[SCAN_W-1:ROUTE_W] ^ CHAN_XOR;
    route_next         = route;
    if (scan.switch_closed) begin
      route_next[sel_chan] = scan_position[ROUTE_W-1:0];
    end
    scan_position_next = scan_position + SCAN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_position <= '0;
      for (int i = 0; i < N_CHAN; i++) begin
        route[i] <= route_t'(i);
      end
    end else if (scan_accept) begin
      scan_position <= scan_position_next;
      route         <= route_next;
    end
  end

  // input register
  logic [SAMPLE_W-1:0] s1_cv;
  logic [SAMPLE_W-1:0] s1_pos;
  logic [SAMPLE_W-1:0] s1_width;
  route_map_t          s1_route;
  logic [SCAN_W-1:0]   s1_scan;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan.ready) begin
      s1_valid <= scan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_accept) begin
      s1_cv    <= scan.cv_sample;
      s1_pos   <= scan.position_sample;
      s1_width <= scan.width_sample;
      s1_route <= route_next;
      s1_scan  <= scan_position_next;
    end
  end

  // window position and width
  logic signed [POS_W-1:0]   x_pos;
  logic signed [WIDTH_W-1:0] w_width;

  assign x_pos   = $signed(POS_W'(s1_cv) + POS_W'(s1_pos) - POS_CENTRE);
  assign w_width = $signed(WIDTH_W'(width_base) - WIDTH_W'(s1_width >> 3));

  gain_t gain [N_CHAN];

  for (genvar g = 0; g < N_CHAN; g++) begin : g_win
    cfr_window u_win (
      .pos    (x_pos),
      .width  (w_width),
      .centre (CENTRES[g]),
      .gain   (gain[g])
    );
  end

  // route gains to outputs, sum, saturate; LEDs use the raw gain
  logic [SUM_W-1:0]   sum [N_CHAN];
  logic [LEVEL_W-1:0] level [N_CHAN];
  logic [N_CHAN-1:0]  led;

  always_comb begin
    for (int j = 0; j < N_CHAN; j++) begin
      sum[j] = '0;
      for (int i = 0; i < N_CHAN; i++) begin
        if (s1_route[i] == route_t'(j)) begin
          sum[j] = sum[j] + SUM_W'(gain[i]);
        end
      end
      level[j] = (sum[j] > LEVEL_MAX) ? LEVEL_MAX[LEVEL_W-1:0] : sum[j][LEVEL_W-1:0];
    end
    for (int i = 0; i < N_CHAN; i++) begin
      led[i] = gain[i] > GAIN_W'(led_threshold);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      levels.level_a            <= level[0];
      levels.level_b            <= level[1];
      levels.level_c            <= level[2];
      levels.level_d            <= level[3];
      levels.led_mask           <= led;
      levels.next_scan_position <= s1_scan;
    end
  end

  assign levels.valid = out_valid;

  // checks
  a_scan_step: assert property (@(posedge clk) disable iff (rst)
    scan_accept |=> scan_position == $past(scan_position) + SCAN_W'(1))
    else $error("scan position did not advance on accepted beat");

  a_scan_hold: assert property (@(posedge clk) disable iff (rst)
    !scan_accept |=> $stable(scan_position) && $stable(route))
    else $error("scan state moved without a beat");

  a_stage_move: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_advance |=> out_valid)
    else $error("item lost between input and result register");

  a_reset_route: assert property (@(posedge clk)
    rst |=> scan_position == '0 && route[0] == route_t'(0) && route[3] == route_t'(3))
    else $error("scan state not cleared by reset");

endmodule

// ===== sim/cfr_checker.sv =====
// Scoreboard for the crossfade router: predicts each level beat from the scan beats and compares.
module cfr_checker
  import cfr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  cfr_scan_if                    scan,
  cfr_level_if                   levels,
  output int                     fails,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_a;
    logic [LEVEL_W-1:0] level_b;
    logic [LEVEL_W-1:0] level_c;
    logic [LEVEL_W-1:0] level_d;
    logic [N_CHAN-1:0]  led_mask;
    logic [SCAN_W-1:0]  next_scan_position;
  } level_beat_t;

  logic [SAMPLE_W-1:0] width_base;
  logic [LEVEL_W-1:0]  led_threshold;
  logic [SCAN_W-1:0]   scan_pos;
  route_map_t          routes;
  level_beat_t         expected_levels [$];
  int                  n_bad;
  int                  n_beats;

  task automatic report(input string field, input int got, input int want);
    $display("MISMATCH level beat %0d %s: got %0d, want %0d", n_beats, field, got, want);
    n_bad++;
  endtask

  // Routing update, scan advance, window gains, LED mask and saturated output sums.
  function automatic level_beat_t crossfade_levels(input logic sw,
                                                   input logic [SAMPLE_W-1:0] cv,
                                                   input logic [SAMPLE_W-1:0] pos,
                                                   input logic [SAMPLE_W-1:0] wsm);
    int          x;
    int          w;
    int          d;
    int          g;
    int          sums [N_CHAN];
    gain_t       gain;
    route_t      ch;
    level_beat_t r;
    r = '0;
    sums = '{default: 0};
    if (sw) begin
      ch = route_t'(scan_pos[SCAN_W-1:2]) ^ CHAN_XOR;
      routes[ch] = scan_pos[1:0];
    end
    scan_pos = scan_pos + 1'b1;
    x = int'(cv) + int'(pos) - int'(POS_CENTRE);
    w = int'(width_base) - int'(wsm >> 3);
    for (int i = 0; i < N_CHAN; i++) begin
      d = x - int'(CENTRES[i]);
      if (d < 0) d = -d;
      g = w - d;
      gain = (g < 0) ? '0 : gain_t'(g << 3);
      if (gain > led_threshold) r.led_mask[i] = 1'b1;
      sums[routes[i]] += int'(gain);
    end
    for (int i = 0; i < N_CHAN; i++)
      if (sums[i] > int'(LEVEL_MAX)) sums[i] = int'(LEVEL_MAX);
    r.level_a = LEVEL_W'(sums[0]);
    r.level_b = LEVEL_W'(sums[1]);
    r.level_c = LEVEL_W'(sums[2]);
    r.level_d = LEVEL_W'(sums[3]);
    r.next_scan_position = scan_pos;
    return r;
  endfunction

  always @(posedge clk) begin
    level_beat_t want;
    if (rst) begin
      width_base    = WIDTH_BASE_RESET;
      led_threshold = LED_THRESHOLD_RESET;
      scan_pos      = '0;
      for (int i = 0; i < N_CHAN; i++) routes[i] = route_t'(i);
      expected_levels.delete();
      n_bad   = 0;
      n_beats = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_WIDTH_BASE:    width_base    = cfg_data[SAMPLE_W-1:0];
          REG_LED_THRESHOLD: led_threshold = cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end
      // a result never leaves in the cycle its scan beat is taken, so compare before pushing
      if (levels.valid && levels.ready) begin
        if (expected_levels.size() == 0) begin
          report("with no prediction waiting", 1, 0);
        end else begin
          want = expected_levels.pop_front();
          if (levels.level_a !== want.level_a) report("level_a", levels.level_a, want.level_a);
          if (levels.level_b !== want.level_b) report("level_b", levels.level_b, want.level_b);
          if (levels.level_c !== want.level_c) report("level_c", levels.level_c, want.level_c);
          if (levels.level_d !== want.level_d) report("level_d", levels.level_d, want.level_d);
          if (levels.led_mask !== want.led_mask)
            report("led_mask", levels.led_mask, want.led_mask);
          if (levels.next_scan_position !== want.next_scan_position)
            report("next_scan_position", levels.next_scan_position, want.next_scan_position);
        end
        n_beats++;
      end
      if (scan.valid && scan.ready)
        expected_levels.push_back(crossfade_levels(scan.switch_closed, scan.cv_sample,
                                                   scan.position_sample, scan.width_sample));
    end
    fails   <= n_bad;
    pending <= expected_levels.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the four-window crossfade router: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cfr_pkg::*;

  localparam int N_DIRECTED    = 20;
  localparam int N_SWEEP       = 16;     // directed beats with the switch closed
  localparam int N_PHASES      = 6;
  localparam int PHASE_BEATS   = 190;
  localparam int HOLD_CYCLES   = 80;     // long receiver hold-off, fills both stages
  localparam int SETTLE_CYCLES = 6;      // two-stage pipe, plus margin
  localparam int CYCLE_LIMIT   = 200000;

  // Directed beats. Most sit at pos = 512 so the window position equals cv:
  // both rails, each window centre, points between centres, width extremes.
  localparam int DIRECTED_CV [N_DIRECTED] = '{
    0, 1023, 0, 341, 682, 1023, 170, 511, 852, 512,
    1023, 0, 340, 683, 100, 900, 170, 512, 853, 0};
  localparam int DIRECTED_POS [N_DIRECTED] = '{
    0, 1023, 512, 512, 512, 512, 512, 512, 512, 512,
    0, 1023, 512, 512, 512, 512, 512, 512, 512, 512};
  localparam int DIRECTED_WSM [N_DIRECTED] = '{
    0, 1023, 0, 0, 0, 0, 0, 8, 1016, 7,
    512, 1023, 1023, 3, 500, 100, 0, 0, 0, 0};

  typedef struct {
    logic                sw;
    logic [SAMPLE_W-1:0] cv;
    logic [SAMPLE_W-1:0] pos;
    logic [SAMPLE_W-1:0] wsm;
  } scan_beat_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fails;
  int                     pending;
  int                     tx_idle_pct = 27;
  int                     rx_idle_pct = 70;
  bit                     hold_request;
  int                     cycles;

  cfr_scan_if  scan ();
  cfr_level_if levels ();

  four_window_crossfade_router dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .scan      (scan),
    .levels    (levels)
  );

  cfr_checker level_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .scan      (scan),
    .levels    (levels),
    .fails     (fails),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random back-pressure at rx_idle_pct, or one long hold-off on request.
  // The hold is counted here so the sender keeps offering beats throughout.
  initial begin
    levels.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        levels.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        levels.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: a hang or a lost beat ends here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Offer one scan beat, with random idle cycles first, and return at the edge it is taken.
  task automatic put_scan(input scan_beat_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      scan.valid <= 1'b0;
      @(posedge clk);
    end
    scan.valid           <= 1'b1;
    scan.switch_closed   <= b.sw;
    scan.cv_sample       <= b.cv;
    scan.position_sample <= b.pos;
    scan.width_sample    <= b.wsm;
    @(posedge clk);
    while (!scan.ready) @(posedge clk);
  endtask

  // Drop valid, let every predicted beat come out, then give the pipe time to empty.
  task automatic settle();
    scan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Random scan beat. A quarter of them aim the window position near a centre,
  // where gains are large and LED thresholds get crossed.
  function automatic scan_beat_t random_scan();
    scan_beat_t b;
    int         tgt;
    int         p;
    b.sw  = ($urandom_range(99) < 35);
    b.cv  = SAMPLE_W'($urandom_range(1023));
    b.wsm = SAMPLE_W'($urandom_range(1023));
    if ($urandom_range(3) == 0) begin
      tgt = int'(CENTRES[$urandom_range(N_CHAN-1)]) + int'($urandom_range(64)) - 32;
      p = tgt - int'(b.cv) + int'(POS_CENTRE);
      if (p < 0) p = 0;
      if (p > 1023) p = 1023;
      b.pos = SAMPLE_W'(p);
    end else begin
      b.pos = SAMPLE_W'($urandom_range(1023));
    end
    return b;
  endfunction

  initial begin
    scan_beat_t b;
    int         wb;
    int         thr;
    rst                  <= 1'b1;
    cfg_write            <= 1'b0;
    cfg_index            <= REG_WIDTH_BASE;
    cfg_data             <= '0;
    scan.valid           <= 1'b0;
    scan.switch_closed   <= 1'b0;
    scan.cv_sample       <= '0;
    scan.position_sample <= '0;
    scan.width_sample    <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset register values. The first sixteen beats close the
    // switch at every scan position in turn, so routes change under live sums and
    // end with all four channels on output 3, leaving outputs 0..2 unused.
    for (int i = 0; i < N_DIRECTED; i++) begin
      b.sw  = (i < N_SWEEP);
      b.cv  = SAMPLE_W'(DIRECTED_CV[i]);
      b.pos = SAMPLE_W'(DIRECTED_POS[i]);
      b.wsm = SAMPLE_W'(DIRECTED_WSM[i]);
      put_scan(b);
    end

    // Random phases, each with its own register setting, written while idle.
    // Zero base makes the width zero or negative; full base gives the largest gains.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          wb  = 1023;
          thr = 0;
        end
        1: begin
          wb  = 0;
          thr = 4095;
        end
        2: begin
          wb  = 1023;
          thr = 4095;
        end
        4: begin
          wb  = int'(WIDTH_BASE_RESET);
          thr = int'(LED_THRESHOLD_RESET);
        end
        default: begin
          wb  = $urandom_range(1023);
          thr = $urandom_range(4095);
        end
      endcase
      write_reg(REG_WIDTH_BASE, CFG_DATA_W'(wb));
      write_reg(REG_LED_THRESHOLD, CFG_DATA_W'(thr));
      // sender-light/receiver-heavy idling, then swapped, then none
      case (ph / 2)
        0: begin
          tx_idle_pct = 27;
          rx_idle_pct = 70;
        end
        1: begin
          tx_idle_pct = 70;
          rx_idle_pct = 27;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (ph == 4) hold_request = 1'b1;
      repeat (PHASE_BEATS) put_scan(random_scan());
    end
    settle();

    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
